// ----- src/rmth_pkg.sv -----
// Shared constants, command codes and types of the running median unit.
package rmth_pkg;

    localparam int CAPACITY = 1024;
    localparam int CELLS    = (CAPACITY + 1) / 2;
    localparam int IDX_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int SCNT_W   = $clog2(CAPACITY + 1);
    localparam int SAMPLE_W = 32;
    localparam int POS_W    = 11;

    typedef logic [1:0] t_op;

    localparam t_op OP_HOLD    = 2'd0;
    localparam t_op OP_INSERT  = 2'd1;
    localparam t_op OP_REPLACE = 2'd2;

    typedef struct packed {
        t_op                        op;
        logic signed [SAMPLE_W-1:0] x;
    } t_chain_cmd;

endpackage

// ----- src/rmth_in_if.sv -----
// Sample channel of the running median unit.
interface rmth_in_if import rmth_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink (input valid, input sample, input start_req, output ready);
endinterface

// ----- src/rmth_out_if.sv -----
// Median result channel of the running median unit.
interface rmth_out_if import rmth_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] median;
    logic [POS_W-1:0]           position;
    logic                       dropped;

    modport source (output valid, output median, output position, output dropped,
                    input ready);
    modport sink (input valid, input median, input position, input dropped,
                  output ready);
endinterface

// ----- src/running_median_two_heaps_unit.sv -----
// Running median unit: two sorted cell chains for the lower and upper halves.
//
//  Channel  Dir  Payload                      Handshake
//  i_in     in   sample, start_req            valid/ready, taken when both high
//  o_out    out  median, position, dropped    valid/ready, taken when both high
//
// Each item passes through four steps: accept, decide, chain update, result hand-off.
// The decide step compares the sample with both chain heads; the update step
// updates every cell of both chains together. Only odd positions and
// dropped samples give a result. A result waits in the output register, so the
// next item is taken meanwhile; a second result stalls until the first is read.
// Reset clears the counts and the control state; cell contents need no reset.
module running_median_two_heaps_unit import rmth_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rmth_in_if.sink    i_in,
    rmth_out_if.source o_out
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]                 r_state,        n_state;
    logic [CNT_W-1:0]           r_lower_count,  n_lower_count;
    logic [CNT_W-1:0]           r_upper_count,  n_upper_count;
    logic [SCNT_W-1:0]          r_sample_count, n_sample_count;
    logic                       r_out_valid,    n_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    t_chain_cmd                 r_lower_cmd,    n_lower_cmd;
    t_chain_cmd                 r_upper_cmd,    n_upper_cmd;
    logic                       r_emit,         n_emit;
    logic                       r_dropped,      n_dropped;
    logic signed [SAMPLE_W-1:0] r_median;
    logic [POS_W-1:0]           r_position;
    logic                       r_out_dropped;

    logic                       w_accept;
    logic                       w_load_out;
    logic                       w_full;
    logic                       w_to_lower;
    logic                       w_balanced;
    logic                       w_keep_upper;
    logic signed [SAMPLE_W-1:0] w_lower_top;
    logic signed [SAMPLE_W-1:0] w_upper_top;
    t_chain_cmd                 w_lower_apply;
    t_chain_cmd                 w_upper_apply;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_load_out = (r_state == S_DONE) && r_emit && (!r_out_valid || o_out.ready);

    always_comb begin
        w_full       = (r_sample_count >= SCNT_W'(CAPACITY));
        w_to_lower   = (r_lower_count == '0) || (r_sample <= w_lower_top);
        w_balanced   = (r_lower_count == r_upper_count);
        w_keep_upper = (r_upper_count == '0) || (r_sample <= w_upper_top);
    end

    always_comb begin
        n_state        = r_state;
        n_lower_count  = r_lower_count;
        n_upper_count  = r_upper_count;
        n_sample_count = r_sample_count;
        n_lower_cmd    = r_lower_cmd;
        n_upper_cmd    = r_upper_cmd;
        n_emit         = r_emit;
        n_dropped      = r_dropped;
        n_out_valid    = r_out_valid;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECIDE;
                    if (i_in.start_req) begin
                        n_lower_count  = '0;
                        n_upper_count  = '0;
                        n_sample_count = '0;
                    end
                end
            end
            S_DECIDE: begin
                n_state        = S_APPLY;
                n_lower_cmd.op = OP_HOLD;
                n_lower_cmd.x  = r_sample;
                n_upper_cmd.op = OP_HOLD;
                n_upper_cmd.x  = r_sample;
                if (w_full) begin
                    n_emit    = 1'b1;
                    n_dropped = 1'b1;
                end else begin
                    n_sample_count = r_sample_count + SCNT_W'(1);
                    n_emit         = n_sample_count[0];
                    n_dropped      = 1'b0;
                    if (w_to_lower && !w_balanced) begin
                        // The lower head moves up and the sample takes its place.
                        n_lower_cmd.op = OP_REPLACE;
                        n_upper_cmd.op = OP_INSERT;
                        n_upper_cmd.x  = w_lower_top;
                    end else if (w_to_lower || (w_balanced && w_keep_upper)) begin
                        n_lower_cmd.op = OP_INSERT;
                    end else if (w_balanced) begin
                        // The upper head moves down and the sample takes its place.
                        n_upper_cmd.op = OP_REPLACE;
                        n_lower_cmd.op = OP_INSERT;
                        n_lower_cmd.x  = w_upper_top;
                    end else begin
                        n_upper_cmd.op = OP_INSERT;
                    end
                end
            end
            S_APPLY: begin
                n_state = S_DONE;
                if (r_lower_cmd.op == OP_INSERT) begin
                    n_lower_count = r_lower_count + CNT_W'(1);
                end
                if (r_upper_cmd.op == OP_INSERT) begin
                    n_upper_count = r_upper_count + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_emit) begin
                    n_state = S_IDLE;
                end else if (w_load_out) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_lower_count  <= '0;
            r_upper_count  <= '0;
            r_sample_count <= '0;
            r_out_valid    <= 1'b0;
            r_emit         <= 1'b0;
            r_dropped      <= 1'b0;
            r_lower_cmd    <= '0;
            r_upper_cmd    <= '0;
        end else begin
            r_state        <= n_state;
            r_lower_count  <= n_lower_count;
            r_upper_count  <= n_upper_count;
            r_sample_count <= n_sample_count;
            r_out_valid    <= n_out_valid;
            r_emit         <= n_emit;
            r_dropped      <= n_dropped;
            r_lower_cmd    <= n_lower_cmd;
            r_upper_cmd    <= n_upper_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_in.sample;
        end
        if (w_load_out) begin
            r_median      <= w_lower_top;
            r_position    <= POS_W'(r_sample_count);
            r_out_dropped <= r_dropped;
        end
    end

    // The chains only move during the update cycle.
    always_comb begin
        w_lower_apply = r_lower_cmd;
        w_upper_apply = r_upper_cmd;
        if (r_state != S_APPLY) begin
            w_lower_apply.op = OP_HOLD;
            w_upper_apply.op = OP_HOLD;
        end
    end

    rmth_chain u_lower (
        .i_clk   (i_clk),
        .i_desc  (1'b1),
        .i_count (r_lower_count),
        .i_cmd   (w_lower_apply),
        .o_top   (w_lower_top)
    );

    rmth_chain u_upper (
        .i_clk   (i_clk),
        .i_desc  (1'b0),
        .i_count (r_upper_count),
        .i_cmd   (w_upper_apply),
        .o_top   (w_upper_top)
    );

    assign o_out.valid    = r_out_valid;
    assign o_out.median   = r_median;
    assign o_out.position = r_position;
    assign o_out.dropped  = r_out_dropped;

endmodule

// ----- src/rmth_cell.sv -----
// One cell of a sorted chain: holds one value and shifts it with its neighbors.
module rmth_cell import rmth_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_desc,
    input  logic [IDX_W-1:0]           i_index,
    input  logic [CNT_W-1:0]           i_count,
    input  t_chain_cmd                 i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_left_value,
    input  logic                       i_left_stay,
    input  logic signed [SAMPLE_W-1:0] i_right_value,
    input  logic                       i_right_stay,
    output logic signed [SAMPLE_W-1:0] o_value,
    output logic                       o_stay
);

    logic signed [SAMPLE_W-1:0] r_value;
    logic signed [SAMPLE_W-1:0] n_value;
    logic                       w_valid;
    logic                       w_above;
    logic                       w_first;

    // A cell "stays" when it holds a live value that sorts ahead of the
    // incoming item; the stay flags form a prefix of the chain.
    always_comb begin
        w_valid = (CNT_W'(i_index) < i_count);
        w_above = i_desc ? (r_value >= i_cmd.x) : (r_value <= i_cmd.x);
        w_first = (i_index == '0);
        o_stay  = w_valid && w_above;
    end

    always_comb begin
        case (i_cmd.op)
            OP_INSERT: begin
                if (o_stay) begin
                    n_value = r_value;
                end else if (i_left_stay) begin
                    n_value = i_cmd.x;
                end else begin
                    n_value = i_left_value;
                end
            end
            // Drop the head and insert in the same cycle: the chain first
            // moves up by one, then the item drops into its place.
            OP_REPLACE: begin
                if (i_right_stay) begin
                    n_value = i_right_value;
                end else if (o_stay || w_first) begin
                    n_value = i_cmd.x;
                end else begin
                    n_value = r_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- src/rmth_chain.sv -----
// Sorted chain of cells that stands in for one heap; cell 0 holds the top.
module rmth_chain import rmth_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_desc,
    input  logic [CNT_W-1:0]           i_count,
    input  t_chain_cmd                 i_cmd,
    output logic signed [SAMPLE_W-1:0] o_top
);

    logic signed [SAMPLE_W-1:0] w_value [CELLS];
    logic                       w_stay  [CELLS];

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic signed [SAMPLE_W-1:0] w_left_value;
        logic                       w_left_stay;
        logic signed [SAMPLE_W-1:0] w_right_value;
        logic                       w_right_stay;

        if (g == 0) begin : g_head
            assign w_left_value = '0;
            assign w_left_stay  = 1'b1;
        end else begin : g_body_left
            assign w_left_value = w_value[g-1];
            assign w_left_stay  = w_stay[g-1];
        end

        if (g == CELLS - 1) begin : g_tail
            assign w_right_value = '0;
            assign w_right_stay  = 1'b0;
        end else begin : g_body_right
            assign w_right_value = w_value[g+1];
            assign w_right_stay  = w_stay[g+1];
        end

        rmth_cell u_cell (
            .i_clk         (i_clk),
            .i_desc        (i_desc),
            .i_index       (IDX_W'(g)),
            .i_count       (i_count),
            .i_cmd         (i_cmd),
            .i_left_value  (w_left_value),
            .i_left_stay   (w_left_stay),
            .i_right_value (w_right_value),
            .i_right_stay  (w_right_stay),
            .o_value       (w_value[g]),
            .o_stay        (w_stay[g])
        );
    end

    assign o_top = w_value[0];

endmodule
